// File: hw/rtl/jlmp_pkg.sv
package jlmp_pkg;

   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DIVN_W  = 64;
   localparam int DIVD_W  = 33;
   localparam int TSHIFT  = 24;
   localparam int TERM_W  = 36;

   localparam logic [31:0] RECIP6       = 32'hAAAA_AAAB;
   localparam int          RECIP6_SHIFT = 34;

   localparam logic [31:0] TENTH_Q16     = 32'd6554;
   localparam logic [31:0] HUNDREDTH_Q16 = 32'd655;

   localparam logic [2:0] CSR_JERK_LIMIT     = 3'd0;
   localparam logic [2:0] CSR_ACCEL_LIMIT    = 3'd1;
   localparam logic [2:0] CSR_SPEED_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_STEP_TIME      = 3'd3;
   localparam logic [2:0] CSR_STEPS_PER_UNIT = 3'd4;

   typedef enum logic [1:0] {
      JERK_ZERO = 2'd0,
      JERK_POS  = 2'd1,
      JERK_NEG  = 2'd2
   } jerk_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_M1,
      S_M2,
      S_M3,
      S_M4,
      S_DIV1,
      S_DIV2,
      S_JERK,
      S_P1,
      S_P2,
      S_P3,
      S_P4,
      S_P5,
      S_P6,
      S_P7,
      S_UPD,
      S_END,
      S_RATE,
      S_OUT
   } state_type;

endpackage

// File: hw/rtl/jerk_limited_motion_profile_core.sv
// channel  | ports                          | payload, lowest bit first
// request  | req_tvalid/tready/tdata/tuser  | tuser: operation; tdata: target_position
// response | rsp_tvalid/tready/tdata        | tdata: status, direction, step_rate,
//          |                                |   stop_driver, position, velocity, accel
// csr      | csr_we/csr_index/csr_wdata     | jerk, accel, speed, step_time, steps/unit
//
// Start requests and idle or zero-step ticks go from S_IDLE to S_OUT; a wrong-way
// stop passes through S_CHECK first. A running tick waits on two back to
// back 64-step radix-2 divisions; one 32x32 multiplier serves all products.
// Reset is synchronous and clears motion state and loads register defaults.
// A finished response is held in the output register while the next
// request is taken; the sequencer waits in S_OUT only while that register is full and rsp_tready is low.
module jerk_limited_motion_profile_core
   import jlmp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // target_position
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // status, direction, step_rate, stop_driver,
                                     // position, velocity, acceleration, zero pad
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int W = VALUE_WIDTH;

   function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] x);
      logic signed [63:0] hi, lo;
      hi = (64'sd1 <<< (W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (x > hi) return hi[W-1:0];
      if (x < lo) return lo[W-1:0];
      return x[W-1:0];
   endfunction

   function automatic logic signed [TERM_W-1:0] term(input logic neg, input logic [31:0] m);
      logic signed [TERM_W-1:0] t;
      t = $signed({{(TERM_W-32){1'b0}}, m});
      return neg ? -t : t;
   endfunction

   function automatic logic [W:0] mag_w(input logic signed [W:0] x);
      return x[W] ? (W+1)'(0) - x : x;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      return x[31] ? 32'd0 - x : x;
   endfunction

   state_type state_ff, state_in;
   jerk_type  jerk_ff, jerk_in;

   logic [30:0] jl_ff, al_ff, vl_ff;
   logic [23:0] dt_ff;
   logic [31:0] spu_ff;

   logic signed [W-1:0] pos_ff, pos_in, goal_ff, goal_in;
   logic signed [31:0]  vel_ff, vel_in, acc_ff, acc_in;
   logic                run_ff, run_in;

   logic signed [W:0]        dx_ff, dx_in;
   logic                     fwd_ff, fwd_in;
   logic [63:0]              tmp_ff, tmp_in, sd_ff, sd_in;
   logic [23:0]              dt2_ff, dt2_in, dt3_ff, dt3_in;
   logic signed [TERM_W-1:0] dpos_ff, dpos_in, vn_ff, vn_in, an_ff, an_in;

   logic        rs_st_ff, rs_st_in, rs_dir_ff, rs_dir_in, rs_stp_ff, rs_stp_in;
   logic [31:0] rs_rate_ff, rs_rate_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [135:0] rsp_data_ff, rsp_data_in;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic              div_start, div_done;
   logic [DIVN_W-1:0] div_n, quo;
   logic [DIVD_W-1:0] div_d;

   logic [30:0]              adiv, jdiv;
   logic signed [W:0]        dx_now, err_now;
   logic [W:0]               adx;
   logic [31:0]              speed, jmag;
   logic signed [32:0]       sa;
   logic                     brake, at_lim, jneg, fin;
   logic signed [63:0]       pos_sum;
   logic signed [TERM_W-1:0] amax_s, vmax_s;
   logic signed [63:0]       pos_x;

   jlmp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   jlmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done_ff  (div_done),
      .quo_ff   (quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      adiv    = (al_ff == 31'd0) ? 31'd1 : al_ff;
      jdiv    = (jl_ff == 31'd0) ? 31'd1 : jl_ff;
      dx_now  = $signed({goal_ff[W-1], goal_ff}) - $signed({pos_ff[W-1], pos_ff});
      err_now = $signed({pos_ff[W-1], pos_ff}) - $signed({goal_ff[W-1], goal_ff});
      adx     = mag_w(dx_ff);
      speed   = mag32(vel_ff);
      jneg    = (jerk_ff == JERK_NEG);
      jmag    = (jerk_ff == JERK_ZERO) ? 32'd0 : {1'b0, jl_ff};
      sa      = fwd_ff ? $signed({acc_ff[31], acc_ff}) : -$signed({acc_ff[31], acc_ff});
      brake   = (fwd_ff ? !vel_ff[31] : (vel_ff <= 32'sd0))
                && ({{(63-W){1'b0}}, adx} <= sd_ff);
      at_lim  = speed >= {1'b0, vl_ff};
      amax_s  = $signed({{(TERM_W-31){1'b0}}, al_ff});
      vmax_s  = $signed({{(TERM_W-31){1'b0}}, vl_ff});
      pos_x   = {{(64-W){pos_ff[W-1]}}, pos_ff};
      pos_sum = pos_x + {{(64-TERM_W){dpos_ff[TERM_W-1]}}, dpos_ff};
      fin     = ((adx < (W+1)'(TENTH_Q16)) && (speed < TENTH_Q16))
                || (mag_w(err_now) < (W+1)'(HUNDREDTH_Q16));

      state_in     = state_ff;
      jerk_in      = jerk_ff;
      pos_in       = pos_ff;
      goal_in      = goal_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      run_in       = run_ff;
      dx_in        = dx_ff;
      fwd_in       = fwd_ff;
      tmp_in       = tmp_ff;
      sd_in        = sd_ff;
      dt2_in       = dt2_ff;
      dt3_in       = dt3_ff;
      dpos_in      = dpos_ff;
      vn_in        = vn_ff;
      an_in        = an_ff;
      rs_st_in     = rs_st_ff;
      rs_dir_in    = rs_dir_ff;
      rs_stp_in    = rs_stp_ff;
      rs_rate_in   = rs_rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_n        = '0;
      div_d        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rs_dir_in  = 1'b0;
               rs_stp_in  = 1'b0;
               rs_rate_in = '0;
               if (req_tuser) begin
                  goal_in  = sat_w({{32{req_tdata[31]}}, req_tdata});
                  run_in   = 1'b1;
                  rs_st_in = 1'b1;
                  state_in = S_OUT;
               end else if (!run_ff || dt_ff == 24'd0) begin
                  rs_st_in = run_ff;
                  state_in = S_OUT;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            dx_in  = dx_now;
            fwd_in = !dx_now[W];
            mul_a  = speed;
            mul_b  = speed;
            if ((vel_ff > 32'sd0 && dx_now < 0) || (vel_ff < 32'sd0 && dx_now > 0)) begin
               state_in = S_END;
               run_in   = 1'b0;
               pos_in   = goal_ff;
               vel_in   = '0;
               acc_in   = '0;
               rs_st_in = 1'b0;
               rs_dir_in = 1'b0;
               rs_rate_in = '0;
               rs_stp_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            div_start  = 1'b1;
            div_n      = prod;
            div_d      = {1'b0, adiv, 1'b0};
            mul_a      = speed;
            mul_b      = {1'b0, al_ff};
            state_in   = S_M2;
         end
         S_M2: begin
            tmp_in   = prod;
            mul_a    = {8'd0, dt_ff};
            mul_b    = {8'd0, dt_ff};
            state_in = S_M3;
         end
         S_M3: begin
            dt2_in   = prod[TSHIFT+23:TSHIFT];
            mul_a    = {8'd0, prod[TSHIFT+23:TSHIFT]};
            mul_b    = {8'd0, dt_ff};
            state_in = S_M4;
         end
         S_M4: begin
            dt3_in   = prod[TSHIFT+23:TSHIFT];
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) begin
               sd_in      = quo;
               div_start  = 1'b1;
               div_n      = tmp_ff;
               div_d      = {2'b0, jdiv};
               state_in   = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               sd_in    = sd_ff + quo;
               state_in = S_JERK;
            end
         end
         S_JERK: begin
            if (brake || at_lim) begin
               if (sa > 33'sd0) jerk_in = fwd_ff ? JERK_NEG : JERK_POS;
               else if (sa < 33'sd0 && speed > TENTH_Q16) jerk_in = JERK_ZERO;
               else jerk_in = fwd_ff ? JERK_POS : JERK_NEG;
            end else begin
               jerk_in = (sa < $signed({2'b0, al_ff})) ? (fwd_ff ? JERK_POS : JERK_NEG)
                                                      : JERK_ZERO;
            end
            mul_a    = speed;
            mul_b    = {8'd0, dt_ff};
            state_in = S_P1;
         end
         S_P1: begin
            dpos_in  = term(vel_ff[31], prod[TSHIFT+31:TSHIFT]);
            mul_a    = mag32(acc_ff);
            mul_b    = {8'd0, dt2_ff};
            state_in = S_P2;
         end
         S_P2: begin
            dpos_in  = dpos_ff + term(acc_ff[31], prod[TSHIFT+32:TSHIFT+1]);
            mul_a    = jmag;
            mul_b    = {8'd0, dt3_ff};
            state_in = S_P3;
         end
         S_P3: begin
            mul_a    = prod[TSHIFT+31:TSHIFT];
            mul_b    = RECIP6;
            state_in = S_P4;
         end
         S_P4: begin
            dpos_in  = dpos_ff + term(jneg, {{(RECIP6_SHIFT-32){1'b0}},
                                             prod[PROD_W-1:RECIP6_SHIFT]});
            mul_a    = mag32(acc_ff);
            mul_b    = {8'd0, dt_ff};
            state_in = S_P5;
         end
         S_P5: begin
            vn_in    = $signed({{(TERM_W-32){vel_ff[31]}}, vel_ff})
                       + term(acc_ff[31], prod[TSHIFT+31:TSHIFT]);
            mul_a    = jmag;
            mul_b    = {8'd0, dt2_ff};
            state_in = S_P6;
         end
         S_P6: begin
            vn_in    = vn_ff + term(jneg, prod[TSHIFT+32:TSHIFT+1]);
            mul_a    = jmag;
            mul_b    = {8'd0, dt_ff};
            state_in = S_P7;
         end
         S_P7: begin
            an_in    = $signed({{(TERM_W-32){acc_ff[31]}}, acc_ff})
                       + term(jneg, prod[TSHIFT+31:TSHIFT]);
            state_in = S_UPD;
         end
         S_UPD: begin
            pos_in = sat_w(pos_sum);
            if (an_ff > amax_s) acc_in = amax_s[31:0];
            else if (an_ff < -amax_s) acc_in = 32'(-amax_s);
            else acc_in = an_ff[31:0];
            if (vn_ff > vmax_s) vel_in = vmax_s[31:0];
            else if (vn_ff < -vmax_s) vel_in = 32'(-vmax_s);
            else vel_in = vn_ff[31:0];
            state_in = S_END;
         end
         S_END: begin
            mul_a = speed;
            mul_b = spu_ff;
            if (fin) begin
               run_in     = 1'b0;
               pos_in     = goal_ff;
               vel_in     = '0;
               acc_in     = '0;
               rs_st_in   = 1'b0;
               rs_dir_in  = 1'b0;
               rs_rate_in = '0;
               rs_stp_in  = 1'b1;
               state_in   = S_OUT;
            end else begin
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            rs_st_in   = 1'b1;
            rs_dir_in  = !fwd_ff;
            rs_stp_in  = 1'b0;
            rs_rate_in = (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, acc_ff, vel_ff, pos_x[31:0], rs_stp_ff,
                               rs_rate_ff, rs_dir_ff, rs_st_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         jerk_ff      <= JERK_ZERO;
         pos_ff       <= '0;
         goal_ff      <= '0;
         vel_ff       <= '0;
         acc_ff       <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         jl_ff        <= 31'd65536;
         al_ff        <= 31'd65536;
         vl_ff        <= 31'd65536;
         dt_ff        <= 24'd16777;
         spu_ff       <= 32'd65536;
      end else begin
         state_ff     <= state_in;
         jerk_ff      <= jerk_in;
         pos_ff       <= pos_in;
         goal_ff      <= goal_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_JERK_LIMIT:     jl_ff  <= csr_wdata[30:0];
               CSR_ACCEL_LIMIT:    al_ff  <= csr_wdata[30:0];
               CSR_SPEED_LIMIT:    vl_ff  <= csr_wdata[30:0];
               CSR_STEP_TIME:      dt_ff  <= csr_wdata[23:0];
               CSR_STEPS_PER_UNIT: spu_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      dx_ff       <= dx_in;
      fwd_ff      <= fwd_in;
      tmp_ff      <= tmp_in;
      sd_ff       <= sd_in;
      dt2_ff      <= dt2_in;
      dt3_ff      <= dt3_in;
      dpos_ff     <= dpos_in;
      vn_ff       <= vn_in;
      an_ff       <= an_in;
      rs_st_ff    <= rs_st_in;
      rs_dir_ff   <= rs_dir_in;
      rs_stp_ff   <= rs_stp_in;
      rs_rate_ff  <= rs_rate_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hw/rtl/jlmp_mul.sv
module jlmp_mul
   import jlmp_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hw/rtl/jlmp_div.sv
module jlmp_div
   import jlmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done_ff,
   output logic [DIVN_W-1:0] quo_ff
);

   localparam int CNT_W = $clog2(DIVN_W);

   logic              busy_ff, busy_in, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIVN_W-1:0] quo_in;
   logic [DIVD_W:0]   trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
         quo_in = {quo_ff[DIVN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule
